@@ design/wplv_pkg.sv @@
// Shared types, codes and constants for the partitioned LRU victim block.
`default_nettype none
package wplv_pkg;

	localparam int unsigned WAYS      = 16;
	localparam int unsigned LANES     = 8;
	localparam int unsigned WAY_W     = 4;
	localparam int unsigned SET_IDX_W = 10;
	localparam int unsigned WEIGHT_W  = 10;
	localparam int unsigned LIMIT_W   = 10;
	localparam int unsigned TIME_W    = 48;
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		OP_TOUCH      = 2'd0,
		OP_INSERT     = 2'd1,
		OP_INVALIDATE = 2'd2,
		OP_VICTIM     = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ZERO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ONE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TWO  = 2'd2;

	localparam logic [LIMIT_W-1:0] LIMIT_ZERO_RST = 10'd100;
	localparam logic [LIMIT_W-1:0] LIMIT_ONE_RST  = 10'd250;
	localparam logic [LIMIT_W-1:0] LIMIT_TWO_RST  = 10'd400;

	typedef enum logic [1:0] {
		GRP_LOW  = 2'd0,
		GRP_MID  = 2'd1,
		GRP_HIGH = 2'd2,
		GRP_TOP  = 2'd3
	} grp_t;

	// One candidate entering the compare tree.
	typedef struct packed {
		logic             en;
		logic [WAY_W-1:0] way;
	} lane_tag_t;

	function automatic logic [WAY_W-1:0] grp_base(input grp_t g);
		logic [WAY_W-1:0] b;
		case (g)
			GRP_LOW:  b = 4'd0;
			GRP_MID:  b = 4'd4;
			GRP_HIGH: b = 4'd12;
			GRP_TOP:  b = 4'd14;
			default:  b = 4'd0;
		endcase
		return b;
	endfunction

	function automatic logic [WAY_W-1:0] grp_count(input grp_t g);
		logic [WAY_W-1:0] c;
		case (g)
			GRP_LOW:  c = 4'd4;
			GRP_MID:  c = 4'd8;
			GRP_HIGH: c = 4'd2;
			GRP_TOP:  c = 4'd2;
			default:  c = 4'd2;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ design/way_partitioned_lru_victim.sv @@
// Top level: partitioned least-recently-touched victim selection for a 16-way cache.
// One request is in flight at a time. Touch, insert and invalidate go from the request
// register to the pending and output registers; a victim request first passes the memory
// read and three compare stages. A new request is taken the cycle after the previous result
// enters the output register. After reset a clearing pass writes zero to every set, one row
// a cycle, while input is stalled; the limits reset to 100, 250 and 400.
`default_nettype none
module way_partitioned_lru_victim #(
	parameter int unsigned SETS       = 1024,
	parameter int unsigned STAMP_BITS = 48
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [wplv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [wplv_pkg::LIMIT_W-1:0]        cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          opcode,
	input  wire logic [wplv_pkg::SET_IDX_W-1:0]      set_index,
	input  wire logic [wplv_pkg::WAY_W-1:0]          way_index,
	input  wire logic [wplv_pkg::WEIGHT_W-1:0]       data_weight,
	input  wire logic [wplv_pkg::TIME_W-1:0]         now_time,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [wplv_pkg::WAY_W-1:0]          victim_way,
	output logic                                     victim_valid
);

	localparam int unsigned AW    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned ROW_W = wplv_pkg::WAYS * STAMP_BITS;
	localparam int unsigned LW    = wplv_pkg::LANES * STAMP_BITS;

	logic [wplv_pkg::LIMIT_W-1:0] limit_zero_q;
	logic [wplv_pkg::LIMIT_W-1:0] limit_one_q;
	logic [wplv_pkg::LIMIT_W-1:0] limit_two_q;

	logic                         clearing_q;
	logic [AW-1:0]                clr_cnt_q;
	logic                         busy_q;

	logic                         accept;
	logic [31:0]                  set_wide;
	logic [63:0]                  now_wide;
	logic                         set_ok;
	wplv_pkg::grp_t               grp;

	logic                         req_valid_s1;
	wplv_pkg::op_t                op_s1;
	logic                         set_ok_s1;
	logic [AW-1:0]                addr_s1;
	logic [wplv_pkg::WAY_W-1:0]   way_s1;
	wplv_pkg::grp_t               grp_s1;
	logic [STAMP_BITS-1:0]        stamp_s1;
	logic                         read_valid_s2;

	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [wplv_pkg::WAYS-1:0]    mem_wmask;
	logic [ROW_W-1:0]             mem_wdata;
	logic                         mem_re;
	logic [ROW_W-1:0]             mem_rdata;

	logic [LW-1:0]                lane_stamps;
	wplv_pkg::lane_tag_t [wplv_pkg::LANES-1:0] lane_tags;
	logic [wplv_pkg::WAY_W-1:0]   lane_base;
	logic [wplv_pkg::WAY_W-1:0]   lane_count;
	logic                         tree_valid;
	logic [wplv_pkg::WAY_W-1:0]   tree_way;

	logic                         write_done;
	logic                         pend_valid_q;
	logic [wplv_pkg::WAY_W-1:0]   pend_way_q;
	logic                         pend_victim_q;
	logic                         out_valid_q;
	logic [wplv_pkg::WAY_W-1:0]   out_way_q;
	logic                         out_victim_q;
	logic                         out_free;

	assign in_stall = busy_q | clearing_q;
	assign accept   = in_valid & ~in_stall;

	assign set_wide = {{(32 - wplv_pkg::SET_IDX_W){1'b0}}, set_index};
	assign now_wide = {{(64 - wplv_pkg::TIME_W){1'b0}}, now_time};
	assign set_ok   = set_wide < 32'(SETS);

	// Thresholds are tested as a priority chain, lowest group first.
	always_comb begin
		if (data_weight <= limit_zero_q) begin
			grp = wplv_pkg::GRP_LOW;
		end else if (data_weight <= limit_one_q) begin
			grp = wplv_pkg::GRP_MID;
		end else if (data_weight <= limit_two_q) begin
			grp = wplv_pkg::GRP_HIGH;
		end else begin
			grp = wplv_pkg::GRP_TOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_zero_q <= wplv_pkg::LIMIT_ZERO_RST;
			limit_one_q  <= wplv_pkg::LIMIT_ONE_RST;
			limit_two_q  <= wplv_pkg::LIMIT_TWO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				wplv_pkg::CFG_LIMIT_ZERO: limit_zero_q <= cfg_data;
				wplv_pkg::CFG_LIMIT_ONE:  limit_one_q  <= cfg_data;
				wplv_pkg::CFG_LIMIT_TWO:  limit_two_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == AW'(SETS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1  <= 1'b0;
			read_valid_s2 <= 1'b0;
		end else begin
			req_valid_s1  <= accept;
			read_valid_s2 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= wplv_pkg::op_t'(opcode);
			set_ok_s1 <= set_ok;
			addr_s1   <= set_wide[AW-1:0];
			way_s1    <= way_index;
			grp_s1    <= grp;
			if (opcode == wplv_pkg::OP_INVALIDATE) begin
				stamp_s1 <= '0;
			end else begin
				stamp_s1 <= now_wide[STAMP_BITS-1:0];
			end
		end
	end

	// Clearing owns the write port; requests only run once it is done.
	assign mem_we    = clearing_q |
	                   (req_valid_s1 & (op_s1 != wplv_pkg::OP_VICTIM) & set_ok_s1);
	assign mem_waddr = clearing_q ? clr_cnt_q : addr_s1;
	assign mem_wmask = clearing_q ? {wplv_pkg::WAYS{1'b1}}
	                              : ({{(wplv_pkg::WAYS-1){1'b0}}, 1'b1} << way_s1);
	assign mem_wdata = clearing_q ? '0 : {wplv_pkg::WAYS{stamp_s1}};
	assign mem_re    = req_valid_s1 & (op_s1 == wplv_pkg::OP_VICTIM);

	wplv_stamp_mem #(
		.SETS       (SETS),
		.STAMP_BITS (STAMP_BITS),
		.AW         (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wmask (mem_wmask),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr_s1),
		.rdata (mem_rdata)
	);

	// A set out of range reads as all zero stamps, so the lowest way of the group wins.
	assign lane_base  = wplv_pkg::grp_base(grp_s1);
	assign lane_count = wplv_pkg::grp_count(grp_s1);

	always_comb begin
		for (int i = 0; i < int'(wplv_pkg::LANES); i++) begin
			lane_tags[i].way = lane_base + wplv_pkg::WAY_W'(i);
			lane_tags[i].en  = wplv_pkg::WAY_W'(i) < lane_count;
			if (set_ok_s1) begin
				lane_stamps[i*STAMP_BITS +: STAMP_BITS] =
					mem_rdata[int'(lane_tags[i].way)*STAMP_BITS +: STAMP_BITS];
			end else begin
				lane_stamps[i*STAMP_BITS +: STAMP_BITS] = '0;
			end
		end
	end

	wplv_oldest_tree #(
		.STAMP_BITS (STAMP_BITS)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (read_valid_s2),
		.stamps    (lane_stamps),
		.tags      (lane_tags),
		.out_valid (tree_valid),
		.out_way   (tree_way)
	);

	assign write_done = req_valid_s1 & (op_s1 != wplv_pkg::OP_VICTIM);
	assign out_free   = ~out_valid_q | ~out_stall;

	// The result waits in the pending register until the output register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end
			if (write_done || tree_valid) begin
				pend_valid_q <= 1'b1;
			end
			if (pend_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
				busy_q       <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (write_done) begin
			pend_way_q    <= '0;
			pend_victim_q <= 1'b0;
		end else if (tree_valid) begin
			pend_way_q    <= tree_way;
			pend_victim_q <= 1'b1;
		end
		if (pend_valid_q && out_free) begin
			out_way_q    <= pend_way_q;
			out_victim_q <= pend_victim_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign victim_way   = out_way_q;
	assign victim_valid = out_victim_q;

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("accepted transfer did not mark the block busy");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> in_stall)
		else $error("input not stalled during clearing pass");

	a_tree_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(tree_valid || read_valid_s2 || req_valid_s1) |-> busy_q)
		else $error("work in flight while block is idle");

	a_no_pending_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !(write_done || tree_valid))
		else $error("new result while pending register is full");

	a_plain_result_way_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !victim_valid) |-> (victim_way == '0))
		else $error("non-victim result carries a nonzero way");

endmodule
`default_nettype wire

@@ design/wplv_stamp_mem.sv @@
// Stamp memory: one row of all way stamps per set, per-way write mask, registered read.
`default_nettype none
module wplv_stamp_mem #(
	parameter int unsigned SETS       = 1024,
	parameter int unsigned STAMP_BITS = 48,
	parameter int unsigned AW         = 10
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [AW-1:0]                            waddr,
	input  wire logic [wplv_pkg::WAYS-1:0]                wmask,
	input  wire logic [wplv_pkg::WAYS*STAMP_BITS-1:0]     wdata,
	input  wire logic                                     re,
	input  wire logic [AW-1:0]                            raddr,
	output logic      [wplv_pkg::WAYS*STAMP_BITS-1:0]     rdata
);

	localparam int unsigned ROW_W = wplv_pkg::WAYS * STAMP_BITS;

	logic [ROW_W-1:0] mem [SETS];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int w = 0; w < int'(wplv_pkg::WAYS); w++) begin
				if (wmask[w]) begin
					mem[waddr][w*STAMP_BITS +: STAMP_BITS] <= wdata[w*STAMP_BITS +: STAMP_BITS];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ design/wplv_oldest_tree.sv @@
// Three-stage registered compare tree that finds the oldest of eight candidate stamps.
`default_nettype none
module wplv_oldest_tree #(
	parameter int unsigned STAMP_BITS = 48
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          in_valid,
	input  wire logic [wplv_pkg::LANES*STAMP_BITS-1:0]         stamps,
	input  wire wplv_pkg::lane_tag_t [wplv_pkg::LANES-1:0]     tags,
	output logic                                               out_valid,
	output logic      [wplv_pkg::WAY_W-1:0]                    out_way
);

	logic [STAMP_BITS-1:0] st_d1 [4];
	wplv_pkg::lane_tag_t   tg_d1 [4];
	logic [STAMP_BITS-1:0] st_s1 [4];
	wplv_pkg::lane_tag_t   tg_s1 [4];
	logic [STAMP_BITS-1:0] st_d2 [2];
	wplv_pkg::lane_tag_t   tg_d2 [2];
	logic [STAMP_BITS-1:0] st_s2 [2];
	wplv_pkg::lane_tag_t   tg_s2 [2];
	wplv_pkg::lane_tag_t   tg_d3;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  valid_s3;
	logic [wplv_pkg::WAY_W-1:0] way_s3;

	// The right candidate always has the higher way, so it wins only when strictly older.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (tags[2*k+1].en &&
			    (stamps[(2*k+1)*STAMP_BITS +: STAMP_BITS] < stamps[2*k*STAMP_BITS +: STAMP_BITS])) begin
				st_d1[k] = stamps[(2*k+1)*STAMP_BITS +: STAMP_BITS];
				tg_d1[k] = tags[2*k+1];
			end else begin
				st_d1[k] = stamps[2*k*STAMP_BITS +: STAMP_BITS];
				tg_d1[k] = tags[2*k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			if (tg_s1[2*k+1].en && (st_s1[2*k+1] < st_s1[2*k])) begin
				st_d2[k] = st_s1[2*k+1];
				tg_d2[k] = tg_s1[2*k+1];
			end else begin
				st_d2[k] = st_s1[2*k];
				tg_d2[k] = tg_s1[2*k];
			end
		end
	end

	always_comb begin
		if (tg_s2[1].en && (st_s2[1] < st_s2[0])) begin
			tg_d3 = tg_s2[1];
		end else begin
			tg_d3 = tg_s2[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		st_s1  <= st_d1;
		tg_s1  <= tg_d1;
		st_s2  <= st_d2;
		tg_s2  <= tg_d2;
		way_s3 <= tg_d3.way;
	end

	assign out_valid = valid_s3;
	assign out_way   = way_s3;

endmodule
`default_nettype wire

@@ test/tb_way_partitioned_lru_victim.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the partitioned LRU victim selector: directed table, then random phases.
module tb_way_partitioned_lru_victim;

	localparam int unsigned NUM_SETS        = 1024;
	localparam int unsigned DIR_ROWS        = 25;
	localparam int unsigned RAND_PHASES     = 6;
	localparam int unsigned ITEMS_PER_PHASE = 105;
	localparam int unsigned HOT_SETS        = 8;
	localparam int unsigned WATCHDOG_LIMIT  = 4000;
	localparam int unsigned LONG_HOLD       = 80;
	localparam int unsigned DRAIN_CYCLES    = 10;
	localparam logic [wplv_pkg::TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		wplv_pkg::op_t                  op;
		logic [wplv_pkg::SET_IDX_W-1:0] set_idx;
		logic [wplv_pkg::WAY_W-1:0]     way;
		logic [wplv_pkg::WEIGHT_W-1:0]  weight;
		logic [wplv_pkg::TIME_W-1:0]    now;
	} lru_req_t;

	typedef struct packed {
		logic [wplv_pkg::WAY_W-1:0] way;
		logic                       valid;
	} victim_t;

	typedef struct packed {
		lru_req_t req;
		logic     known;
		victim_t  res;
	} dir_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [wplv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [wplv_pkg::LIMIT_W-1:0]   cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [1:0]                     opcode = '0;
	logic [wplv_pkg::SET_IDX_W-1:0] set_index = '0;
	logic [wplv_pkg::WAY_W-1:0]     way_index = '0;
	logic [wplv_pkg::WEIGHT_W-1:0]  data_weight = '0;
	logic [wplv_pkg::TIME_W-1:0]    now_time = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [wplv_pkg::WAY_W-1:0]     victim_way;
	logic                           victim_valid;

	// Predictor state.
	logic [wplv_pkg::TIME_W-1:0]    stamp_store [NUM_SETS][wplv_pkg::WAYS];
	logic [wplv_pkg::LIMIT_W-1:0]   lim_zero = wplv_pkg::LIMIT_ZERO_RST;
	logic [wplv_pkg::LIMIT_W-1:0]   lim_one  = wplv_pkg::LIMIT_ONE_RST;
	logic [wplv_pkg::LIMIT_W-1:0]   lim_two  = wplv_pkg::LIMIT_TWO_RST;
	victim_t                        pending_victims [$];

	logic [wplv_pkg::SET_IDX_W-1:0] hot_sets [HOT_SETS];
	logic [wplv_pkg::TIME_W-1:0]    clock_stamp = '0;
	int unsigned                    errors = 0;
	int unsigned                    results_seen = 0;
	int unsigned                    quiet_cycles = 0;
	bit                             tx_quiet = 1'b0;
	bit                             rx_quiet = 1'b0;
	bit                             long_hold_done = 1'b0;

	// Expected values are typed in only where all stamps are still zero or no victim is asked.
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{'{wplv_pkg::OP_VICTIM, 10'd0, 4'd0, 10'd0, 48'd0}, 1'b1, '{4'd0, 1'b1}},
		'{'{wplv_pkg::OP_VICTIM, 10'd1023, 4'd15, 10'd1023, TIME_MAX}, 1'b1, '{4'd14, 1'b1}},
		'{'{wplv_pkg::OP_VICTIM, 10'd5, 4'd0, 10'd100, 48'd0}, 1'b1, '{4'd0, 1'b1}},
		'{'{wplv_pkg::OP_VICTIM, 10'd5, 4'd0, 10'd101, 48'd0}, 1'b1, '{4'd4, 1'b1}},
		'{'{wplv_pkg::OP_VICTIM, 10'd5, 4'd0, 10'd250, 48'd0}, 1'b1, '{4'd4, 1'b1}},
		'{'{wplv_pkg::OP_VICTIM, 10'd5, 4'd0, 10'd251, 48'd0}, 1'b1, '{4'd12, 1'b1}},
		'{'{wplv_pkg::OP_VICTIM, 10'd5, 4'd0, 10'd400, 48'd0}, 1'b1, '{4'd12, 1'b1}},
		'{'{wplv_pkg::OP_VICTIM, 10'd5, 4'd0, 10'd401, 48'd0}, 1'b1, '{4'd14, 1'b1}},
		'{'{wplv_pkg::OP_TOUCH, 10'd0, 4'd0, 10'd0, TIME_MAX}, 1'b1, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_INSERT, 10'd0, 4'd1, 10'd1023, 48'd1}, 1'b1, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_TOUCH, 10'd0, 4'd2, 10'd0, 48'd2}, 1'b1, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_TOUCH, 10'd0, 4'd3, 10'd0, 48'd3}, 1'b1, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_VICTIM, 10'd0, 4'd0, 10'd0, 48'd0}, 1'b0, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_INVALIDATE, 10'd0, 4'd2, 10'd0, TIME_MAX}, 1'b1, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_VICTIM, 10'd0, 4'd15, 10'd77, 48'd0}, 1'b0, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_TOUCH, 10'd1023, 4'd15, 10'd0, 48'd5}, 1'b1, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_VICTIM, 10'd1023, 4'd0, 10'd1023, 48'd0}, 1'b0, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_TOUCH, 10'd1023, 4'd14, 10'd0, 48'd7}, 1'b1, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_VICTIM, 10'd1023, 4'd0, 10'd1023, 48'd0}, 1'b0, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_TOUCH, 10'd1023, 4'd15, 10'd0, 48'd7}, 1'b1, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_VICTIM, 10'd1023, 4'd0, 10'd1023, 48'd0}, 1'b0, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_INSERT, 10'd512, 4'd11, 10'd0, 48'h8000_0000_0000}, 1'b1,
			'{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_INSERT, 10'd512, 4'd4, 10'd0, 48'd1}, 1'b1, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_VICTIM, 10'd512, 4'd7, 10'd200, 48'd0}, 1'b0, '{4'd0, 1'b0}},
		'{'{wplv_pkg::OP_INVALIDATE, 10'd1023, 4'd15, 10'd512, 48'd9}, 1'b1, '{4'd0, 1'b0}}
	};

	way_partitioned_lru_victim #(
		.SETS       (NUM_SETS),
		.STAMP_BITS (wplv_pkg::TIME_W)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.set_index    (set_index),
		.way_index    (way_index),
		.data_weight  (data_weight),
		.now_time     (now_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.victim_way   (victim_way),
		.victim_valid (victim_valid)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Oldest stamp among count ways from first; the lowest way wins a tie.
	function automatic logic [wplv_pkg::WAY_W-1:0] oldest_way(
			input logic [wplv_pkg::SET_IDX_W-1:0] s,
			input int unsigned first, input int unsigned count);
		logic [wplv_pkg::WAY_W-1:0]  best;
		logic [wplv_pkg::TIME_W-1:0] best_stamp;
		best = wplv_pkg::WAY_W'(first);
		if (s >= NUM_SETS)
			return best;
		best_stamp = stamp_store[s][first];
		for (int unsigned w = first + 1; w < first + count; w++) begin
			if (stamp_store[s][w] < best_stamp) begin
				best_stamp = stamp_store[s][w];
				best = wplv_pkg::WAY_W'(w);
			end
		end
		return best;
	endfunction

	function automatic victim_t apply_request(input lru_req_t r);
		victim_t v;
		v = '0;
		case (r.op)
			wplv_pkg::OP_TOUCH, wplv_pkg::OP_INSERT: begin
				if (r.set_idx < NUM_SETS)
					stamp_store[r.set_idx][r.way] = r.now;
			end
			wplv_pkg::OP_INVALIDATE: begin
				if (r.set_idx < NUM_SETS)
					stamp_store[r.set_idx][r.way] = '0;
			end
			default: begin
				v.valid = 1'b1;
				// The limits act as a priority chain, so out-of-order values are legal.
				if (r.weight <= lim_zero)
					v.way = oldest_way(r.set_idx, 0, 4);
				else if (r.weight <= lim_one)
					v.way = oldest_way(r.set_idx, 4, 8);
				else if (r.weight <= lim_two)
					v.way = oldest_way(r.set_idx, 12, 2);
				else
					v.way = oldest_way(r.set_idx, 14, 2);
			end
		endcase
		return v;
	endfunction

	// Mostly a few hot sets so that stamps build up; weights cluster around the limits.
	function automatic lru_req_t random_request();
		lru_req_t                     r;
		int unsigned                  pick;
		logic [wplv_pkg::LIMIT_W-1:0] lim;
		pick = $urandom_range(0, 99);
		r.op = pick < 30 ? wplv_pkg::OP_TOUCH : pick < 50 ? wplv_pkg::OP_INSERT :
			pick < 62 ? wplv_pkg::OP_INVALIDATE : wplv_pkg::OP_VICTIM;
		if ($urandom_range(0, 6) == 0)
			r.set_idx = wplv_pkg::SET_IDX_W'($urandom);
		else
			r.set_idx = hot_sets[$urandom_range(0, HOT_SETS - 1)];
		r.way = wplv_pkg::WAY_W'($urandom);
		case ($urandom_range(0, 3))
			0, 1: r.weight = wplv_pkg::WEIGHT_W'($urandom);
			default: begin
				pick = $urandom_range(0, 2);
				lim = pick == 0 ? lim_zero : pick == 1 ? lim_one : lim_two;
				r.weight = lim + wplv_pkg::WEIGHT_W'($urandom_range(0, 2))
					- wplv_pkg::WEIGHT_W'(1);
			end
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2: r.now = wplv_pkg::TIME_W'($urandom_range(0, 7));
			3: r.now = TIME_MAX - wplv_pkg::TIME_W'($urandom_range(0, 3));
			4, 5: r.now = wplv_pkg::TIME_W'({$urandom, $urandom});
			default: begin
				clock_stamp = clock_stamp + wplv_pkg::TIME_W'($urandom_range(1, 4));
				r.now = clock_stamp;
			end
		endcase
		return r;
	endfunction

	task automatic offer(input lru_req_t r, input logic known, input victim_t res);
		int unsigned gap;
		victim_t     predicted;
		gap = tx_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opcode <= r.op;
		set_index <= r.set_idx;
		way_index <= r.way;
		data_weight <= r.weight;
		now_time <= r.now;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predicted = apply_request(r);
		pending_victims.push_back(known ? res : predicted);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_victims.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_limits(input logic [wplv_pkg::LIMIT_W-1:0] z,
			input logic [wplv_pkg::LIMIT_W-1:0] o, input logic [wplv_pkg::LIMIT_W-1:0] t);
		cfg_we <= 1'b1;
		cfg_index <= wplv_pkg::CFG_LIMIT_ZERO;
		cfg_data <= z;
		@(posedge clk);
		cfg_index <= wplv_pkg::CFG_LIMIT_ONE;
		cfg_data <= o;
		@(posedge clk);
		cfg_index <= wplv_pkg::CFG_LIMIT_TWO;
		cfg_data <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_zero = z;
		lim_one = o;
		lim_two = t;
	endtask

	initial begin
		logic [wplv_pkg::LIMIT_W-1:0] a, b, c;
		for (int s = 0; s < NUM_SETS; s++)
			for (int w = 0; w < wplv_pkg::WAYS; w++)
				stamp_store[s][w] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < DIR_ROWS; i++)
			offer(directed_rows[i].req, directed_rows[i].known, directed_rows[i].res);
		for (int p = 0; p < RAND_PHASES; p++) begin
			drain();
			case (p)
				0: program_limits('0, '0, '0);
				1: program_limits('1, '1, '1);
				2: program_limits(10'd500, 10'd200, 10'd300);
				3: begin
					a = wplv_pkg::LIMIT_W'($urandom_range(0, 1023));
					b = wplv_pkg::LIMIT_W'($urandom_range(a, 1023));
					c = wplv_pkg::LIMIT_W'($urandom_range(b, 1023));
					program_limits(a, b, c);
				end
				default: program_limits(wplv_pkg::LIMIT_W'($urandom),
					wplv_pkg::LIMIT_W'($urandom), wplv_pkg::LIMIT_W'($urandom));
			endcase
			for (int h = 0; h < HOT_SETS; h++)
				hot_sets[h] = wplv_pkg::SET_IDX_W'($urandom);
			tx_quiet = (p % 3 == 1);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				offer(random_request(), 1'b0, '0);
		end
		drain();
		if (errors == 0)
			$display("** way_partitioned_lru_victim: PASSED **");
		else
			$display("** way_partitioned_lru_victim: FAILED **");
		$finish;
	end

	// Result side: random stalls, plus one long hold that backs the block up into its input.
	initial begin
		int unsigned gap;
		victim_t     want;
		forever begin
			if (!long_hold_done && results_seen >= 150) begin
				gap = LONG_HOLD;
				long_hold_done = 1'b1;
			end else begin
				gap = rx_quiet ? 0 : $urandom_range(0, 14);
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			results_seen++;
			if (results_seen % 64 == 0)
				rx_quiet = ($urandom_range(0, 2) == 0);
			if (pending_victims.size() == 0) begin
				errors++;
				$display("%0t: result with no request pending: victim_way %0d victim_valid %0b",
					$time, victim_way, victim_valid);
			end else begin
				want = pending_victims.pop_front();
				if (victim_way !== want.way) begin
					errors++;
					$display("%0t: victim_way mismatch: expected %0d, actual %0d",
						$time, want.way, victim_way);
				end
				if (victim_valid !== want.valid) begin
					errors++;
					$display("%0t: victim_valid mismatch: expected %0b, actual %0b",
						$time, want.valid, victim_valid);
				end
			end
		end
	end

	// Any transfer on either side restarts the count; the clearing pass after reset fits well inside.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("** way_partitioned_lru_victim: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

@@ sim.f @@
design/wplv_pkg.sv
design/wplv_stamp_mem.sv
design/wplv_oldest_tree.sv
design/way_partitioned_lru_victim.sv
test/tb_way_partitioned_lru_victim.sv
